// ----- sv/mcv_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI CV package
// Types, field widths and message codes shared by the MIDI to CV/gate block.
// ----------------------------------------------------------------------------
package mcv_pkg;

    localparam int unsigned KEY_W       = 8;
    localparam int unsigned VEL_W       = 7;
    localparam int unsigned VEL_STEPS   = 128;
    localparam int unsigned VEL_MAX     = 127;
    localparam int unsigned LEVEL_W     = 12;
    localparam int unsigned LEVEL_MAX   = 4095;
    localparam int unsigned MAP_ENTRIES = 8;
    localparam int unsigned MAP_W       = 64;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned GROUP_SIZE  = 4;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CC_MAP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_MAP       = 2'd2;

    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CC       = 4'hB;

    typedef enum logic [1:0] {
        ACT_IGNORED  = 2'd0,
        ACT_CV       = 2'd1,
        ACT_GATE_ON  = 2'd2,
        ACT_GATE_OFF = 2'd3
    } t_action;

    typedef struct packed {
        logic [7:0]       status_byte;
        logic [KEY_W-1:0] first_data;
        logic [VEL_W-1:0] second_data;
    } t_msg;

    typedef struct packed {
        t_action            action;
        logic [IDX_W-1:0]   matched_index;
        logic               dac_group;
        logic [LEVEL_W-1:0] dac_value_a;
        logic [LEVEL_W-1:0] dac_value_b;
        logic [LEVEL_W-1:0] dac_value_c;
        logic [LEVEL_W-1:0] dac_value_d;
        logic [7:0]         gate_bits;
    } t_res;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_match;

endpackage

// ----- sv/mcv_stream_if.sv -----
// ----------------------------------------------------------------------------
// MIDI CV stream interface
// Valid/ready channel carrying one request of a given payload type.
// ----------------------------------------------------------------------------
interface mcv_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/mcv_match.sv -----
// ----------------------------------------------------------------------------
// MIDI CV map match
// Finds the lowest map entry below the limit whose byte equals the key.
// ----------------------------------------------------------------------------
module mcv_match
    import mcv_pkg::*;
#(
    parameter int unsigned LIMIT = 8
) (
    input  logic [MAP_W-1:0] i_map,
    input  logic [KEY_W-1:0] i_key,
    output t_match           o_match
);

    always_comb begin
        o_match = '0;
        for (int k = int'(MAP_ENTRIES) - 1; k >= 0; k--) begin
            if ((k < int'(LIMIT)) && (i_map[KEY_W*k +: KEY_W] == i_key)) begin
                o_match.hit = 1'b1;
                o_match.idx = IDX_W'(k);
            end
        end
    end

endmodule

// ----- sv/midi_cc_note_to_cv_gate.sv -----
// ----------------------------------------------------------------------------
// MIDI CC and note to CV/gate converter
// Turns decoded MIDI messages into CV levels and gate bits for two DAC groups.
// ----------------------------------------------------------------------------
// Each request on i_msg is one decoded message: status byte and two data
// bytes. Messages on other channels than listen_channel, unmapped controllers
// or notes and other message types give an ignored result. Every request
// gives exactly one result on o_res.
// A request is taken into an input register; the match, scaling and state
// update are done from the input register, and the result is held in an
// output register. One request is accepted per cycle while the receiver
// does not stall; the state has a single compare-and-update pass.
// When the receiver stalls, the result stays in the output register, the
// input register takes a request only while it is empty, and i_msg.ready
// stays low once it holds one.
// The configuration port writes listen_channel, cc_map and note_map.
// Reset clears the configuration, all CV levels, the gate bits and the valid
// flags of both pipeline registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_cc_note_to_cv_gate
    import mcv_pkg::*;
#(
    parameter int unsigned CV_CHANNELS    = 8,
    parameter int unsigned GATE_CHANNELS  = 8,
    parameter int unsigned DAC_FULL_SCALE = 4095
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MAP_W-1:0]     i_cfg_data,
    mcv_stream_if.sink           i_msg,
    mcv_stream_if.source         o_res
);

    logic [CHAN_W-1:0]  r_listen;
    logic [MAP_W-1:0]   r_cc_map;
    logic [MAP_W-1:0]   r_note_map;

    logic               r_in_vld;
    t_msg               r_in;
    logic               r_out_vld;
    t_res               r_res;

    logic [LEVEL_W-1:0] r_cv [CV_CHANNELS];
    logic [LEVEL_W-1:0] n_cv [CV_CHANNELS];
    logic [GATE_CHANNELS-1:0] r_gate;
    logic [GATE_CHANNELS-1:0] n_gate;
    t_res               n_res;

    logic [LEVEL_W-1:0] w_lut [VEL_STEPS];
    logic [LEVEL_W-1:0] w_cv8 [MAP_ENTRIES];
    logic [7:0]         w_gate8;
    t_match             w_cc_match;
    t_match             w_note_match;
    logic               w_out_free;
    logic               w_fire;
    logic               w_chan_ok;
    logic [3:0]         w_type;
    logic               w_do_cv;
    logic               w_do_on;
    logic               w_do_off;

    for (genvar v = 0; v < int'(VEL_STEPS); v++) begin : g_lut
        localparam int unsigned RAW = (v * DAC_FULL_SCALE) / VEL_MAX;
        localparam int unsigned LV  = (RAW > LEVEL_MAX) ? LEVEL_MAX : RAW;
        assign w_lut[v] = LV[LEVEL_W-1:0];
    end

    mcv_match #(
        .LIMIT (CV_CHANNELS)
    ) u_cc_match (
        .i_map   (r_cc_map),
        .i_key   (r_in.first_data),
        .o_match (w_cc_match)
    );

    mcv_match #(
        .LIMIT (GATE_CHANNELS)
    ) u_note_match (
        .i_map   (r_note_map),
        .i_key   (r_in.first_data),
        .o_match (w_note_match)
    );

    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_fire      = r_in_vld && w_out_free;
    assign i_msg.ready = !r_in_vld || w_out_free;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_res;

    assign w_chan_ok = (r_in.status_byte[3:0] == r_listen);
    assign w_type    = r_in.status_byte[7:4];
    assign w_do_cv   = w_chan_ok && (w_type == MSG_CC) && w_cc_match.hit;
    assign w_do_on   = w_chan_ok && (w_type == MSG_NOTE_ON) && (r_in.second_data != '0)
                       && w_note_match.hit;
    assign w_do_off  = w_chan_ok && w_note_match.hit
                       && ((w_type == MSG_NOTE_OFF)
                           || ((w_type == MSG_NOTE_ON) && (r_in.second_data == '0)));

    always_comb begin
        for (int k = 0; k < int'(CV_CHANNELS); k++) begin
            n_cv[k] = r_cv[k];
            if (w_do_cv && (w_cc_match.idx == IDX_W'(k))) begin
                n_cv[k] = w_lut[r_in.second_data];
            end
        end
    end

    always_comb begin
        n_gate = r_gate;
        for (int k = 0; k < int'(GATE_CHANNELS); k++) begin
            if (w_note_match.idx == IDX_W'(k)) begin
                if (w_do_on) begin
                    n_gate[k] = 1'b1;
                end else if (w_do_off) begin
                    n_gate[k] = 1'b0;
                end
            end
        end
    end

    for (genvar j = 0; j < int'(MAP_ENTRIES); j++) begin : g_view
        if (j < int'(CV_CHANNELS)) begin : g_cv
            assign w_cv8[j] = n_cv[j];
        end else begin : g_cv_none
            assign w_cv8[j] = '0;
        end
        if (j < int'(GATE_CHANNELS)) begin : g_gate
            assign w_gate8[j] = n_gate[j];
        end else begin : g_gate_none
            assign w_gate8[j] = 1'b0;
        end
    end

    always_comb begin
        n_res           = '0;
        n_res.action    = ACT_IGNORED;
        n_res.gate_bits = w_gate8;
        if (w_do_cv) begin
            n_res.action        = ACT_CV;
            n_res.matched_index = w_cc_match.idx;
            n_res.dac_group     = w_cc_match.idx[IDX_W-1];
            if (w_cc_match.idx[IDX_W-1]) begin
                n_res.dac_value_a = w_cv8[GROUP_SIZE];
                n_res.dac_value_b = w_cv8[GROUP_SIZE + 1];
                n_res.dac_value_c = w_cv8[GROUP_SIZE + 2];
                n_res.dac_value_d = w_cv8[GROUP_SIZE + 3];
            end else begin
                n_res.dac_value_a = w_cv8[0];
                n_res.dac_value_b = w_cv8[1];
                n_res.dac_value_c = w_cv8[2];
                n_res.dac_value_d = w_cv8[3];
            end
        end else if (w_do_on) begin
            n_res.action        = ACT_GATE_ON;
            n_res.matched_index = w_note_match.idx;
        end else if (w_do_off) begin
            n_res.action        = ACT_GATE_OFF;
            n_res.matched_index = w_note_match.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen   <= '0;
            r_cc_map   <= '0;
            r_note_map <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LISTEN_CHANNEL: r_listen   <= i_cfg_data[CHAN_W-1:0];
                CFG_CC_MAP:         r_cc_map   <= i_cfg_data;
                CFG_NOTE_MAP:       r_note_map <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_gate    <= '0;
            for (int k = 0; k < int'(CV_CHANNELS); k++) begin
                r_cv[k] <= '0;
            end
        end else begin
            if (i_msg.valid && i_msg.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
                r_gate    <= n_gate;
                for (int k = 0; k < int'(CV_CHANNELS); k++) begin
                    r_cv[k] <= n_cv[k];
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_msg.valid && i_msg.ready) begin
            r_in <= i_msg.data;
        end
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.action == ACT_IGNORED))
        |-> ((r_res.matched_index == '0) && !r_res.dac_group))
        else $error("ignored result carries an index or group");

    a_cv_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.action == ACT_CV))
        |-> (r_res.dac_group == r_res.matched_index[IDX_W-1]))
        else $error("DAC group does not hold the updated channel");

    a_gate_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.action == ACT_GATE_ON))
        |-> r_res.gate_bits[r_res.matched_index])
        else $error("raised gate not set in gate bits");

    a_gate_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.action == ACT_GATE_OFF))
        |-> !r_res.gate_bits[r_res.matched_index])
        else $error("lowered gate still set in gate bits");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_msg.ready)
        else $error("input stalled while the output register is empty");

endmodule
